// File: rtl/core/qte_pkg.sv
package qte_pkg;

	localparam int QF = 30;
	localparam int QW = 32;
	localparam int AW = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int CNTW = $clog2(CORDIC_STEPS);
	localparam int ACCW = QW + 6;
	localparam int CW = QW + 8;
	localparam int ZW = QF + 6;
	localparam int RADW = 2 * QF + 2;
	localparam int ROOTW = QF + 1;
	localparam int SQCNTW = $clog2(ROOTW);
	localparam int THRW = 15;
	localparam int SECW = 16;
	localparam int CFGW = 16;
	localparam int SH = 33 - AW;
	localparam int RW = ZW - SH;
	localparam int PCW = 5;

	localparam logic signed [ZW-1:0] PI_Q = ZW'(64'sd3373259426);
	localparam logic signed [RW-1:0] AMAX = RW'((64'sd1 <<< (AW - 1)) - 1);
	localparam logic signed [RW-1:0] AMIN = ~AMAX;

	localparam logic [0:0] CFG_SETTLE = 1'b0;
	localparam logic [0:0] CFG_LIMIT = 1'b1;

	localparam logic [1:0] C_W = 2'd0;
	localparam logic [1:0] C_X = 2'd1;
	localparam logic [1:0] C_Y = 2'd2;
	localparam logic [1:0] C_Z = 2'd3;

	localparam logic [PCW-1:0] MC_EULER = PCW'(16);
	localparam logic [PCW-1:0] MC_LAST = PCW'(26);

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic [SECW-1:0] elapsed_seconds;
	} in_item_t;

	typedef struct packed {
		logic signed [AW-1:0] yaw;
		logic signed [AW-1:0] pitch;
		logic signed [AW-1:0] roll;
		logic signed [QW-1:0] out_w;
		logic signed [QW-1:0] out_x;
		logic signed [QW-1:0] out_y;
		logic signed [QW-1:0] out_z;
	} out_item_t;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
	} quat_t;

	typedef enum logic [1:0] {BK_T, BK_Q, BK_E, BK_S} bank_t;

	typedef enum logic [3:0] {
		D_E0, D_E1, D_E2, D_E3, D_YY, D_YX, D_SS, D_RY, D_RX, D_RAD
	} dst_t;

	typedef struct packed {
		bank_t a_bk;
		logic [1:0] a_ix;
		bank_t b_bk;
		logic [1:0] b_ix;
		logic neg;
		logic first;
		logic wr;
		dst_t dst;
	} mc_t;

	typedef enum logic [1:0] {CSEL_YAW, CSEL_ROLL, CSEL_PITCH} csel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MC, S_DRAIN, S_YAW_GO, S_YAW_RUN, S_ROLL_GO, S_ROLL_RUN,
		S_SQ_WAIT, S_PIT_GO, S_PIT_RUN, S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mc_vld;
		mc_t mc;
		logic cord_start;
		csel_t csel;
		logic sqrt_start;
		logic ang_wr;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic cal;
		logic cord_busy;
		logic sq_busy;
		logic out_free;
	} sts_t;

	function automatic mc_t mk(input bank_t ab, input logic [1:0] ai, input bank_t bb,
			input logic [1:0] bi, input logic ng, input logic fs, input logic wr,
			input dst_t d);
		mc_t m;
		m.a_bk = ab;
		m.a_ix = ai;
		m.b_bk = bb;
		m.b_ix = bi;
		m.neg = ng;
		m.first = fs;
		m.wr = wr;
		m.dst = d;
		return m;
	endfunction

	// Steps 0 to 15 form tare * q; steps 16 to 25 the Euler terms; the last squares s.
	function automatic mc_t mc_rom(input logic [PCW-1:0] pc);
		mc_t m;
		case (pc)
			5'd0: m = mk(BK_T, C_W, BK_Q, C_W, 1'b0, 1'b1, 1'b0, D_E0);
			5'd1: m = mk(BK_T, C_X, BK_Q, C_X, 1'b1, 1'b0, 1'b0, D_E0);
			5'd2: m = mk(BK_T, C_Y, BK_Q, C_Y, 1'b1, 1'b0, 1'b0, D_E0);
			5'd3: m = mk(BK_T, C_Z, BK_Q, C_Z, 1'b1, 1'b0, 1'b1, D_E0);
			5'd4: m = mk(BK_T, C_W, BK_Q, C_X, 1'b0, 1'b1, 1'b0, D_E1);
			5'd5: m = mk(BK_T, C_X, BK_Q, C_W, 1'b0, 1'b0, 1'b0, D_E1);
			5'd6: m = mk(BK_T, C_Y, BK_Q, C_Z, 1'b0, 1'b0, 1'b0, D_E1);
			5'd7: m = mk(BK_T, C_Z, BK_Q, C_Y, 1'b1, 1'b0, 1'b1, D_E1);
			5'd8: m = mk(BK_T, C_W, BK_Q, C_Y, 1'b0, 1'b1, 1'b0, D_E2);
			5'd9: m = mk(BK_T, C_X, BK_Q, C_Z, 1'b1, 1'b0, 1'b0, D_E2);
			5'd10: m = mk(BK_T, C_Y, BK_Q, C_W, 1'b0, 1'b0, 1'b0, D_E2);
			5'd11: m = mk(BK_T, C_Z, BK_Q, C_X, 1'b0, 1'b0, 1'b1, D_E2);
			5'd12: m = mk(BK_T, C_W, BK_Q, C_Z, 1'b0, 1'b1, 1'b0, D_E3);
			5'd13: m = mk(BK_T, C_X, BK_Q, C_Y, 1'b0, 1'b0, 1'b0, D_E3);
			5'd14: m = mk(BK_T, C_Y, BK_Q, C_X, 1'b1, 1'b0, 1'b0, D_E3);
			5'd15: m = mk(BK_T, C_Z, BK_Q, C_W, 1'b0, 1'b0, 1'b1, D_E3);
			5'd16: m = mk(BK_E, C_W, BK_E, C_W, 1'b0, 1'b1, 1'b0, D_YX);
			5'd17: m = mk(BK_E, C_X, BK_E, C_X, 1'b0, 1'b0, 1'b1, D_YX);
			5'd18: m = mk(BK_E, C_X, BK_E, C_Y, 1'b0, 1'b1, 1'b0, D_YY);
			5'd19: m = mk(BK_E, C_W, BK_E, C_Z, 1'b1, 1'b0, 1'b1, D_YY);
			5'd20: m = mk(BK_E, C_X, BK_E, C_Z, 1'b0, 1'b1, 1'b0, D_SS);
			5'd21: m = mk(BK_E, C_W, BK_E, C_Y, 1'b0, 1'b0, 1'b1, D_SS);
			5'd22: m = mk(BK_E, C_Y, BK_E, C_Z, 1'b0, 1'b1, 1'b0, D_RY);
			5'd23: m = mk(BK_E, C_W, BK_E, C_X, 1'b1, 1'b0, 1'b1, D_RY);
			5'd24: m = mk(BK_E, C_W, BK_E, C_W, 1'b0, 1'b1, 1'b0, D_RX);
			5'd25: m = mk(BK_E, C_Z, BK_E, C_Z, 1'b0, 1'b0, 1'b1, D_RX);
			5'd26: m = mk(BK_S, C_W, BK_S, C_W, 1'b0, 1'b1, 1'b1, D_RAD);
			default: m = mk(BK_E, C_W, BK_E, C_W, 1'b0, 1'b1, 1'b0, D_E0);
		endcase
		return m;
	endfunction

	function automatic logic [29:0] atan_tab(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd843314856;
			5'd1: v = 30'd497837829;
			5'd2: v = 30'd263043836;
			5'd3: v = 30'd133525158;
			5'd4: v = 30'd67021686;
			5'd5: v = 30'd33543515;
			5'd6: v = 30'd16775850;
			5'd7: v = 30'd8388437;
			5'd8: v = 30'd4194282;
			5'd9: v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd7;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// Round half up to the angle format, then saturate.
	function automatic logic signed [AW-1:0] to_angle(input logic signed [ZW-1:0] z);
		logic signed [ZW-1:0] t;
		logic signed [RW-1:0] r;
		logic signed [AW-1:0] a;
		t = z + (ZW'(1) <<< (SH - 1));
		r = RW'(t >>> SH);
		if (r > AMAX)
			a = AW'(AMAX);
		else if (r < AMIN)
			a = AW'(AMIN);
		else
			a = AW'(r);
		return a;
	endfunction

endpackage

// File: rtl/core/imu_tare_quaternion_to_euler_unit.sv
// Items are handled one at a time: a calibrated item's result goes into the output register, and the next item
// can be taken in the cycle after that write.
// The time is set by one shared 32x32 multiplier stepping through up to 27 products and by three
// 16-step CORDIC passes in turn; the square root runs beside the first two passes.
// Asynchronous active-low reset clears calibration, the previous angles and the tare,
// and restores the register defaults.
module imu_tare_quaternion_to_euler_unit import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [CFGW-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	qte_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts(sts),
		.cmd(cmd)
	);

	qte_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.in_item(in_item),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in progress");

	a_cordic_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cord_start |-> !sts.cord_busy)
		else $error("CORDIC restarted while busy");

	a_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mc_vld |-> (!sts.cord_busy && !sts.sq_busy))
		else $error("multiplier program overlaps a running unit");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && sts.cal) |-> sts.out_free)
		else $error("result written over an untaken item");
`endif

endmodule

// File: rtl/core/qte_cordic.sv
module qte_cordic import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [CW-1:0] y_in,
	input logic signed [CW-1:0] x_in,
	output logic busy,
	output logic signed [ZW-1:0] z
);

	logic busy_q;
	logic [CNTW-1:0] cnt_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] da;

	always_comb begin
		dx = y_q >>> cnt_q;
		dy = x_q >>> cnt_q;
		da = ZW'($signed({1'b0, atan_tab(5'(cnt_q))}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Left half plane: reflect through the origin and start from plus or minus pi.
			if (x_in < 0) begin
				x_q <= -x_in;
				y_q <= -y_in;
				z_q <= (y_in >= 0) ? PI_Q : -PI_Q;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end
		end
	end

	assign busy = busy_q;
	assign z = z_q;

endmodule

// File: rtl/core/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [RADW-1:0] rad,
	output logic busy,
	output logic [ROOTW-1:0] root
);

	logic busy_q;
	logic [SQCNTW-1:0] cnt_q;
	logic [RADW-1:0] rad_q;
	logic [ROOTW+1:0] rem_q;
	logic [ROOTW-1:0] root_q;
	logic [ROOTW+3:0] rt, trial;

	always_comb begin
		rt = {rem_q, rad_q[RADW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SQCNTW'(ROOTW - 1))
				busy_q <= 1'b0;
		end
	end

	// Restoring square root, one result bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= rad;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (rt >= trial) begin
				rem_q <= (ROOTW + 2)'(rt - trial);
				root_q <= {root_q[ROOTW-2:0], 1'b1};
			end else begin
				rem_q <= (ROOTW + 2)'(rt);
				root_q <= {root_q[ROOTW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// File: rtl/core/qte_dpath.sv
module qte_dpath import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input in_item_t in_item,
	input logic cfg_we,
	input logic [0:0] cfg_idx,
	input logic [CFGW-1:0] cfg_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_item
);

	localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< QF;
	localparam logic signed [CW-1:0] ONE_N = -ONE_C;
	localparam logic signed [ACCW-1:0] Q_MAX = ACCW'(32'sh7fffffff);
	localparam logic signed [ACCW-1:0] Q_MIN = ACCW'(-33'sh80000000);
	localparam logic signed [QW-1:0] Q32_MAX = {1'b0, {(QW - 1){1'b1}}};
	localparam logic signed [QW-1:0] Q32_MIN = {1'b1, {(QW - 1){1'b0}}};
	localparam logic [RADW-1:0] RAD_ONE = RADW'(1) << (2 * QF);

	quat_t q_q, e_q, t_q;
	logic signed [QW-1:0] s_q;
	logic signed [CW-1:0] yy_q, yx_q, ry_q, rx_q;
	logic [RADW-1:0] rad_q;
	logic signed [2*QW-1:0] prod_s1;
	mc_t op_s1;
	logic vld_s1;
	logic signed [ACCW-1:0] acc_q;
	logic signed [AW-1:0] yaw_q, pitch_q, roll_q;
	logic signed [AW-1:0] prev_q [3];
	logic prev_valid_q, cal_q;
	logic [SECW-1:0] elapsed_q;
	logic [THRW-1:0] thr_q;
	logic [SECW-1:0] lim_q;
	logic out_valid_q;
	out_item_t out_q;

	logic signed [QW-1:0] opa, opb;
	logic signed [ACCW-1:0] term, sum;
	logic signed [CW-1:0] sum2;
	logic signed [QW-1:0] sum_sat;
	logic signed [QW-1:0] s_sat;
	logic signed [CW-1:0] cy, cx;
	logic cord_busy, sq_busy;
	logic signed [ZW-1:0] cz;
	logic [ROOTW-1:0] root;
	logic settled, calib;
	logic signed [AW:0] d [3];
	logic [AW:0] ad [3];
	logic signed [AW-1:0] ang [3];

	function automatic logic signed [QW-1:0] pick(input bank_t bk, input logic [1:0] ix,
			input quat_t t, input quat_t q, input quat_t e, input logic signed [QW-1:0] s);
		quat_t v;
		logic signed [QW-1:0] r;
		case (bk)
			BK_T: v = t;
			BK_Q: v = q;
			default: v = e;
		endcase
		case (ix)
			C_W: r = v.w;
			C_X: r = v.x;
			C_Y: r = v.y;
			default: r = v.z;
		endcase
		if (bk == BK_S)
			r = s;
		return r;
	endfunction

	function automatic logic signed [QW-1:0] neg_sat(input logic signed [QW-1:0] v);
		return (v == Q32_MIN) ? Q32_MAX : -v;
	endfunction

	always_comb begin
		opa = pick(cmd.mc.a_bk, cmd.mc.a_ix, t_q, q_q, e_q, s_q);
		opb = pick(cmd.mc.b_bk, cmd.mc.b_ix, t_q, q_q, e_q, s_q);
		term = ACCW'(prod_s1 >>> QF);
		sum = (op_s1.first ? '0 : acc_q) + (op_s1.neg ? -term : term);
		sum2 = CW'(sum) <<< 1;
		if (sum > Q_MAX)
			sum_sat = Q32_MAX;
		else if (sum < Q_MIN)
			sum_sat = Q32_MIN;
		else
			sum_sat = QW'(sum);
		if (sum2 > ONE_C)
			s_sat = QW'(ONE_C);
		else if (sum2 < ONE_N)
			s_sat = QW'(ONE_N);
		else
			s_sat = QW'(sum2);
	end

	always_comb begin
		case (cmd.csel)
			CSEL_YAW: begin
				cy = yy_q;
				cx = yx_q;
			end
			CSEL_ROLL: begin
				cy = ry_q;
				cx = rx_q;
			end
			default: begin
				cy = CW'(s_q);
				cx = $signed(CW'(root));
			end
		endcase
	end

	qte_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.cord_start),
		.y_in(cy),
		.x_in(cx),
		.busy(cord_busy),
		.z(cz)
	);

	qte_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.sqrt_start),
		.rad(rad_q),
		.busy(sq_busy),
		.root(root)
	);

	// Settling test against the previous unsettled sample.
	always_comb begin
		ang[0] = yaw_q;
		ang[1] = pitch_q;
		ang[2] = roll_q;
		settled = prev_valid_q;
		for (int i = 0; i < 3; i++) begin
			d[i] = (AW + 1)'(prev_q[i]) - (AW + 1)'(ang[i]);
			ad[i] = d[i][AW] ? (AW + 1)'(-d[i]) : (AW + 1)'(d[i]);
			if (ad[i] >= (AW + 1)'(thr_q))
				settled = 1'b0;
		end
		calib = settled || (elapsed_q > lim_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			cal_q <= 1'b0;
			prev_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				prev_q[i] <= '0;
			t_q <= '0;
			thr_q <= THRW'(8);
			lim_q <= SECW'(30);
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.mc_vld;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SETTLE: thr_q <= cfg_data[THRW-1:0];
					CFG_LIMIT: lim_q <= cfg_data[SECW-1:0];
					default: ;
				endcase
			end
			if (cmd.fin && !cal_q) begin
				if (calib) begin
					t_q.w <= q_q.w;
					t_q.x <= neg_sat(q_q.x);
					t_q.y <= neg_sat(q_q.y);
					t_q.z <= neg_sat(q_q.z);
					cal_q <= 1'b1;
				end else begin
					for (int i = 0; i < 3; i++)
						prev_q[i] <= ang[i];
					prev_valid_q <= 1'b1;
				end
			end
			if (cmd.fin && cal_q)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q <= {in_item.quat_w, in_item.quat_x, in_item.quat_y, in_item.quat_z};
			e_q <= {in_item.quat_w, in_item.quat_x, in_item.quat_y, in_item.quat_z};
			elapsed_q <= in_item.elapsed_seconds;
		end
		if (cmd.mc_vld) begin
			prod_s1 <= opa * opb;
			op_s1 <= cmd.mc;
		end
		if (vld_s1) begin
			acc_q <= sum;
			if (op_s1.wr) begin
				case (op_s1.dst)
					D_E0: e_q.w <= sum_sat;
					D_E1: e_q.x <= sum_sat;
					D_E2: e_q.y <= sum_sat;
					D_E3: e_q.z <= sum_sat;
					D_YY: yy_q <= sum2;
					D_YX: yx_q <= sum2 - ONE_C;
					D_SS: s_q <= s_sat;
					D_RY: ry_q <= sum2;
					D_RX: rx_q <= sum2 - ONE_C;
					D_RAD: rad_q <= RAD_ONE - RADW'(prod_s1);
					default: ;
				endcase
			end
		end
		if (cmd.ang_wr) begin
			case (cmd.csel)
				CSEL_YAW: yaw_q <= to_angle(-cz);
				CSEL_ROLL: roll_q <= to_angle(-cz);
				default: pitch_q <= to_angle(cz);
			endcase
		end
		if (cmd.fin && cal_q)
			out_q <= {yaw_q, pitch_q, roll_q, e_q.w, e_q.x, e_q.y, e_q.z};
	end

	assign sts.cal = cal_q;
	assign sts.cord_busy = cord_busy;
	assign sts.sq_busy = sq_busy;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// File: rtl/core/qte_ctrl.sv
module qte_ctrl import qte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic [PCW-1:0] pc_q;
	logic accept;

	assign accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept)
				pc_q <= sts.cal ? '0 : MC_EULER;
			else if (state_q == S_MC)
				pc_q <= pc_q + 1'b1;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_MC;
			S_MC: if (pc_q == MC_LAST) state_nxt = S_DRAIN;
			S_DRAIN: state_nxt = S_YAW_GO;
			S_YAW_GO: state_nxt = S_YAW_RUN;
			S_YAW_RUN: if (!sts.cord_busy) state_nxt = S_ROLL_GO;
			S_ROLL_GO: state_nxt = S_ROLL_RUN;
			S_ROLL_RUN: if (!sts.cord_busy) state_nxt = S_SQ_WAIT;
			S_SQ_WAIT: if (!sts.sq_busy) state_nxt = S_PIT_GO;
			S_PIT_GO: state_nxt = S_PIT_RUN;
			S_PIT_RUN: if (!sts.cord_busy) state_nxt = S_FIN;
			S_FIN: if (!sts.cal || sts.out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.mc = mc_rom(pc_q);
		cmd.csel = CSEL_YAW;
		case (state_q)
			S_MC: cmd.mc_vld = 1'b1;
			S_YAW_GO: begin
				cmd.cord_start = 1'b1;
				cmd.sqrt_start = 1'b1;
			end
			S_YAW_RUN: cmd.ang_wr = !sts.cord_busy;
			S_ROLL_GO: begin
				cmd.cord_start = 1'b1;
				cmd.csel = CSEL_ROLL;
			end
			S_ROLL_RUN: begin
				cmd.csel = CSEL_ROLL;
				cmd.ang_wr = !sts.cord_busy;
			end
			S_PIT_GO: begin
				cmd.cord_start = 1'b1;
				cmd.csel = CSEL_PITCH;
			end
			S_PIT_RUN: begin
				cmd.csel = CSEL_PITCH;
				cmd.ang_wr = !sts.cord_busy;
			end
			S_FIN: cmd.fin = !sts.cal || sts.out_free;
			default: ;
		endcase
	end

endmodule
